@@ hdl/aoc_pkg.sv @@
// Shared types and constants of the ARGB over compositor.
package aoc_pkg;

    typedef enum logic [1:0] {
        MODE_KEEP   = 2'd0,
        MODE_MASK   = 2'd1,
        MODE_OPAQUE = 2'd2
    } mode_t;

    localparam logic [1:0] CFG_BOTTOM_MODE = 2'd0;
    localparam logic [1:0] CFG_TOP_MODE    = 2'd1;

    localparam int NUM_W   = 26;
    localparam int DEN_W   = 16;
    localparam int Q_STEPS = 8;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic             zero;
        logic [7:0]       ar;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] num_r;
        logic [NUM_W-1:0] num_g;
        logic [NUM_W-1:0] num_b;
    } mid_entry_t;

endpackage

@@ hdl/aoc_fifo.sv @@
// Small register-based FIFO with occupancy count.
module aoc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic                       full,
    output logic                       empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hdl/aoc_front.sv @@
// Front end: alpha selection, result alpha and per-channel numerators.
module aoc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [31:0]         bottom_pixel,
    input  logic [31:0]         top_pixel,
    input  logic                bottom_mask_bit,
    input  logic                top_mask_bit,
    input  aoc_pkg::mode_t      bottom_mode,
    input  aoc_pkg::mode_t      top_mode,
    output logic [1:0]          busy,
    output logic                out_valid,
    output aoc_pkg::mid_entry_t out_entry
);
    logic        v1_reg, v2_reg;
    logic [7:0]  a1, a2;
    logic [7:0]  a1_reg, a2_reg;
    logic [23:0] c1_reg, c2_reg;
    logic [15:0] tmp_reg, w1_reg, a2k_reg;
    logic [16:0] div_sum;
    logic [7:0]  q255;
    logic [8:0]  a_sum;
    logic [7:0]  ar;
    aoc_pkg::mid_entry_t entry_next, entry_reg;

    always_comb
    begin
        case (bottom_mode)
            aoc_pkg::MODE_MASK:   a1 = bottom_mask_bit ? 8'd0 : aoc_pkg::ALPHA_OPAQUE;
            aoc_pkg::MODE_OPAQUE: a1 = aoc_pkg::ALPHA_OPAQUE;
            default:              a1 = bottom_pixel[31:24];
        endcase
        case (top_mode)
            aoc_pkg::MODE_MASK:   a2 = top_mask_bit ? 8'd0 : aoc_pkg::ALPHA_OPAQUE;
            aoc_pkg::MODE_OPAQUE: a2 = aoc_pkg::ALPHA_OPAQUE;
            default:              a2 = top_pixel[31:24];
        endcase
    end

    // x/255 for x up to 65279, where the quotient fits 8 bits: (x + (x>>8) + 1) >> 8
    assign div_sum = {1'b0, tmp_reg} + {9'd0, tmp_reg[15:8]} + 17'd1;
    assign q255    = div_sum[15:8];
    assign a_sum   = {1'b0, a1_reg} + {1'b0, q255};
    assign ar      = (a_sum > {1'b0, a2_reg}) ? a_sum[7:0] : a2_reg;

    // products are sized by the NUM_W-wide destination
    always_comb
    begin
        entry_next.zero  = (ar == 8'd0);
        entry_next.ar    = ar;
        entry_next.den   = {ar, 8'd0} - {8'd0, ar};
        entry_next.num_r = c1_reg[23:16] * w1_reg + c2_reg[23:16] * a2k_reg;
        entry_next.num_g = c1_reg[15:8] * w1_reg + c2_reg[15:8] * a2k_reg;
        entry_next.num_b = c1_reg[7:0] * w1_reg + c2_reg[7:0] * a2k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg    <= a1;
        a2_reg    <= a2;
        c1_reg    <= bottom_pixel[23:0];
        c2_reg    <= top_pixel[23:0];
        tmp_reg   <= (8'hFF - a1) * a2;
        w1_reg    <= a1 * (8'hFF - a2);
        a2k_reg   <= {a2, 8'd0} - {8'd0, a2};
        entry_reg <= entry_next;
    end

    assign busy      = {1'b0, v1_reg} + {1'b0, v2_reg};
    assign out_valid = v2_reg;
    assign out_entry = entry_reg;

endmodule

@@ hdl/aoc_back.sv @@
// Back end: pipelined restoring dividers for the three color channels.
module aoc_back #(
    parameter int OUT_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           mid_empty,
    input  aoc_pkg::mid_entry_t            mid_entry,
    output logic                           mid_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           out_push,
    output logic [31:0]                    out_pixel
);
    localparam int STAGES = aoc_pkg::Q_STEPS + 1;
    localparam int FL_W   = $clog2(STAGES + 1);
    localparam int NW     = aoc_pkg::NUM_W;

    logic                    valid_reg [STAGES];
    logic [NW-1:0]           rem_reg   [STAGES][3];
    logic [NW-1:0]           rem_next  [STAGES][3];
    logic [7:0]              quo_reg   [STAGES][3];
    logic [7:0]              quo_next  [STAGES][3];
    logic                    sat_reg   [STAGES][3];
    logic [aoc_pkg::DEN_W-1:0] den_reg [STAGES];
    logic [7:0]              ar_reg    [STAGES];
    logic                    zero_reg  [STAGES];
    logic [FL_W-1:0]         inflight_reg, inflight_next;
    logic [NW-1:0]           num_in    [3];
    logic [NW-1:0]           dsh;
    logic [7:0]              chan      [3];

    assign num_in[0] = mid_entry.num_r;
    assign num_in[1] = mid_entry.num_g;
    assign num_in[2] = mid_entry.num_b;

    assign mid_pop = !mid_empty
                   && ((int'(out_count) + int'(inflight_reg)) < OUT_DEPTH);

    // one quotient bit per stage after the first, MSB first
    always_comb
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                rem_next[s][ch] = rem_reg[s][ch];
                quo_next[s][ch] = quo_reg[s][ch];
            end
        end
        for (int s = 1; s < STAGES; s++)
        begin
            dsh = NW'(den_reg[s-1]) << (aoc_pkg::Q_STEPS - s);
            for (int ch = 0; ch < 3; ch++)
            begin
                if (rem_reg[s-1][ch] >= dsh)
                begin
                    rem_next[s][ch] = rem_reg[s-1][ch] - dsh;
                    quo_next[s][ch] = quo_reg[s-1][ch]
                                    | (8'd1 << (aoc_pkg::Q_STEPS - s));
                end
                else
                begin
                    rem_next[s][ch] = rem_reg[s-1][ch];
                    quo_next[s][ch] = quo_reg[s-1][ch];
                end
            end
        end
    end

    assign inflight_next = inflight_reg + FL_W'(mid_pop) - FL_W'(valid_reg[STAGES-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            for (int s = 0; s < STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            inflight_reg <= inflight_next;
            valid_reg[0] <= mid_pop;
            for (int s = 1; s < STAGES; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0]  <= mid_entry.den;
        ar_reg[0]   <= mid_entry.ar;
        zero_reg[0] <= mid_entry.zero;
        for (int ch = 0; ch < 3; ch++)
        begin
            rem_reg[0][ch] <= num_in[ch];
            quo_reg[0][ch] <= 8'd0;
            sat_reg[0][ch] <= num_in[ch] >= {2'd0, mid_entry.den, 8'd0};
        end
        for (int s = 1; s < STAGES; s++)
        begin
            den_reg[s]  <= den_reg[s-1];
            ar_reg[s]   <= ar_reg[s-1];
            zero_reg[s] <= zero_reg[s-1];
            for (int ch = 0; ch < 3; ch++)
            begin
                rem_reg[s][ch] <= rem_next[s][ch];
                quo_reg[s][ch] <= quo_next[s][ch];
                sat_reg[s][ch] <= sat_reg[s-1][ch];
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            chan[ch] = sat_reg[STAGES-1][ch] ? 8'hFF : quo_reg[STAGES-1][ch];
        end
    end

    assign out_push  = valid_reg[STAGES-1];
    assign out_pixel = zero_reg[STAGES-1] ? 32'd0
                     : {ar_reg[STAGES-1], chan[0], chan[1], chan[2]};

endmodule

@@ hdl/argb_over_compositor_core.sv @@
// Top level of the ARGB over compositor.
//
// Channel   | Handshake               | Payload
// ----------+-------------------------+----------------------------------------------
// input     | push / full             | bottom_pixel, top_pixel, bottom/top_mask_bit
// result    | pop / empty             | blended_pixel
// config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One pixel pair per clock sustained while results are popped; a pair passes the front-end
// input and entry registers, the middle queue, 9 divider stages (saturation check plus 8
// quotient bits) and the output queue.
// Reset clears the mode registers, the queues and all valid bits.
// A stalled result side fills the output queue; the back end stops issuing when
// queue plus in-flight divider work would overflow it, then the middle queue fills
// and full rises. Nothing is dropped.
module argb_over_compositor_core #(
    parameter int MID_DEPTH = 8,
    parameter int OUT_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] bottom_pixel,
    input  logic [31:0] top_pixel,
    input  logic        bottom_mask_bit,
    input  logic        top_mask_bit,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] blended_pixel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);
    localparam int MID_W = $bits(aoc_pkg::mid_entry_t);

    aoc_pkg::mode_t bottom_mode_reg, bottom_mode_next;
    aoc_pkg::mode_t top_mode_reg, top_mode_next;

    logic                           accept;
    logic [1:0]                     front_busy;
    logic                           front_valid;
    aoc_pkg::mid_entry_t            front_entry;
    aoc_pkg::mid_entry_t            mid_entry;
    logic [MID_W-1:0]               mid_rdata;
    logic                           mid_pop;
    logic                           mid_empty;
    logic                           mid_full;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic                           out_push;
    logic [31:0]                    out_pixel;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic                           out_full;

    // configuration: always ready, writes to unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        bottom_mode_next = bottom_mode_reg;
        top_mode_next    = top_mode_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                aoc_pkg::CFG_BOTTOM_MODE: bottom_mode_next = aoc_pkg::mode_t'(cfg_data);
                aoc_pkg::CFG_TOP_MODE:    top_mode_next    = aoc_pkg::mode_t'(cfg_data);
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_mode_reg <= aoc_pkg::MODE_KEEP;
            top_mode_reg    <= aoc_pkg::MODE_KEEP;
        end
        else
        begin
            bottom_mode_reg <= bottom_mode_next;
            top_mode_reg    <= top_mode_next;
        end
    end

    // the front end cannot stall, so items in it are counted against the queue
    assign full   = (int'(mid_count) + int'(front_busy)) >= MID_DEPTH;
    assign accept = push && !full;

    aoc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (accept),
        .bottom_pixel    (bottom_pixel),
        .top_pixel       (top_pixel),
        .bottom_mask_bit (bottom_mask_bit),
        .top_mask_bit    (top_mask_bit),
        .bottom_mode     (bottom_mode_reg),
        .top_mode        (top_mode_reg),
        .busy            (front_busy),
        .out_valid       (front_valid),
        .out_entry       (front_entry)
    );

    aoc_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .wdata (front_entry),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .count (mid_count),
        .full  (mid_full),
        .empty (mid_empty)
    );

    assign mid_entry = aoc_pkg::mid_entry_t'(mid_rdata);

    aoc_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_entry (mid_entry),
        .mid_pop   (mid_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_pixel (out_pixel)
    );

    aoc_fifo #(
        .WIDTH (32),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_pixel),
        .pop   (pop),
        .rdata (blended_pixel),
        .count (out_count),
        .full  (out_full),
        .empty (empty)
    );

    // front end transfers must always find room in the middle queue
    assert property (@(posedge clk) disable iff (!rst_n) !(front_valid && mid_full))
        else $error("middle queue overflow");

    // divider results must always find room in the output queue
    assert property (@(posedge clk) disable iff (!rst_n) !(out_push && out_full))
        else $error("output queue overflow");

    // zero result alpha always yields an all-zero pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && blended_pixel[31:24] == 8'd0) |-> (blended_pixel == 32'd0))
        else $error("zero alpha with nonzero color");

    // an accepted item makes the front end busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (front_busy != 2'd0))
        else $error("accepted item lost in front end");

endmodule

@@ tb/tb_argb_over_compositor_core.sv @@
// Testbench of the ARGB over compositor: directed table plus random traffic, checked per pixel.
`timescale 1ns / 1ps

module tb_argb_over_compositor_core;

    // Drain wait after the last result.
    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 750;
    localparam int NUM_DIRECTED = 20;

    // Short names for the mode codes used in the table.
    localparam logic [1:0] M_KEEP  = aoc_pkg::MODE_KEEP;
    localparam logic [1:0] M_MASK  = aoc_pkg::MODE_MASK;
    localparam logic [1:0] M_OPQ   = aoc_pkg::MODE_OPAQUE;
    localparam logic [1:0] M_UNDEF = 2'd3;   // undefined mode, behaves as keep

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [31:0] bottom_pixel;
    logic [31:0] top_pixel;
    logic        bottom_mask_bit;
    logic        top_mask_bit;
    logic        empty;
    logic        pop;
    logic [31:0] blended_pixel;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [1:0]  cfg_data;

    argb_over_compositor_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .bottom_pixel   (bottom_pixel),
        .top_pixel      (top_pixel),
        .bottom_mask_bit(bottom_mask_bit),
        .top_mask_bit   (top_mask_bit),
        .empty          (empty),
        .pop            (pop),
        .blended_pixel  (blended_pixel),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    typedef struct {
        logic [31:0] bottom;
        logic [31:0] top;
        logic        bottom_mask;
        logic        top_mask;
        logic [1:0]  bottom_mode;
        logic [1:0]  top_mode;
        logic        known;     // hand-typed result present
        logic [31:0] blended;
    } pixel_case_t;

    // Local copy of the mode registers, updated on every config transfer.
    logic [1:0]  bottom_mode_q;
    logic [1:0]  top_mode_q;

    logic [31:0] expected_pixels[$];
    int          mismatch_count;
    int          idle_cycles;
    int          results_seen;
    bit          hold_off;      // receiver long-stall request
    bit          stim_done;

    pixel_case_t directed_rows[NUM_DIRECTED];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Alpha source per mode; undefined mode 3 keeps own alpha.
    function automatic logic [7:0] chosen_alpha(logic [31:0] px, logic [1:0] mode, logic mask);
        if (mode == aoc_pkg::MODE_MASK)
            return mask ? 8'd0 : aoc_pkg::ALPHA_OPAQUE;
        if (mode == aoc_pkg::MODE_OPAQUE)
            return aoc_pkg::ALPHA_OPAQUE;
        return px[31:24];
    endfunction

    // Straight-alpha "top over bottom" for one pixel pair.
    function automatic logic [31:0] composite_over(logic [31:0] bot, logic [31:0] top,
                                                   logic bmask, logic tmask,
                                                   logic [1:0] bmode, logic [1:0] tmode);
        int unsigned a1, a2, ar, w1, den, q;
        logic [31:0] res;
        a1 = chosen_alpha(bot, bmode, bmask);
        a2 = chosen_alpha(top, tmode, tmask);
        ar = a1 + ((255 - a1) * a2) / 255;
        if (a2 > ar)
            ar = a2;
        if (ar == 0)
            return 32'd0;
        w1 = a1 * (255 - a2);
        den = ar * 255;
        res = {ar[7:0], 24'd0};
        for (int ch = 0; ch < 3; ch++) begin
            q = (bot[ch*8 +: 8] * w1 + top[ch*8 +: 8] * a2 * 255) / den;
            res[ch*8 +: 8] = (q > 255) ? 8'hFF : q[7:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %08h expected %08h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Config transfer; only called with no result outstanding.
    task automatic write_mode(logic [1:0] idx, logic [1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == aoc_pkg::CFG_BOTTOM_MODE)
            bottom_mode_q = value;
        else
            top_mode_q = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offers one pixel pair at a falling edge, holds until accepted.
    task automatic send_pair(logic [31:0] bot, logic [31:0] top, logic bmask, logic tmask,
                             logic known, logic [31:0] typed);
        logic [31:0] want;
        @(negedge clk);
        push            = 1'b1;
        bottom_pixel    = bot;
        top_pixel       = top;
        bottom_mask_bit = bmask;
        top_mask_bit    = tmask;
        do @(posedge clk); while (full);
        want = composite_over(bot, top, bmask, tmask, bottom_mode_q, top_mode_q);
        if (known && typed !== want)
            report_mismatch("table row vs predictor", want, typed);
        expected_pixels.push_back(want);
    endtask

    task automatic drop_push();
        @(negedge clk);
        push = 1'b0;
    endtask

    // Random pixel: one in three fully random, the rest with alpha or colour at an extreme.
    function automatic logic [31:0] random_pixel();
        logic [31:0] px;
        px = $urandom;
        case ($urandom_range(0, 5))
            0: px[31:24] = 8'h00;
            1: px[31:24] = 8'hFF;
            2: px[23:0]  = 24'hFFFFFF;
            3: px[23:0]  = 24'h000000;
            default: ;
        endcase
        return px;
    endfunction

    // Random phase under one mode setting, sender in bursts with gaps.
    task automatic random_phase(int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            for (int k = 0; k < burst; k++)
                send_pair(random_pixel(), random_pixel(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'b0, 32'd0);
            left -= burst;
            if ($urandom_range(0, 3) != 0) begin
                drop_push();
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
        drop_push();
    endtask

    // Receiver: own stall pattern, plus long hold-off on request.
    initial begin
        int pattern;
        pop = 1'b0;
        pattern = 0;
        forever begin
            @(negedge clk);
            if (hold_off)
                pop = 1'b0;
            else begin
                pattern++;
                case ((pattern / 64) % 3)
                    0: pop = 1'b1;                          // no stalls
                    1: pop = ($urandom_range(0, 3) != 0);
                    default: pop = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Result checker: compare each transfer with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            results_seen++;
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected result", blended_pixel, 32'hx);
            else begin
                logic [31:0] want;
                want = expected_pixels.pop_front();
                if (blended_pixel !== want)
                    report_mismatch("blended_pixel", blended_pixel, want);
            end
        end
    end

    // Watchdog: cycles with no transfer on either side.
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (!stim_done || expected_pixels.size() != 0 || hold_off)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", expected_pixels.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [1:0] bmodes[6];
        logic [1:0] tmodes[6];

        // Directed rows: extremes, every mode, mask effect, zero alpha, saturation.
        directed_rows[0]  = '{32'h00000000, 32'h00000000, 0, 0, M_KEEP, M_KEEP, 1, 32'h0};
        directed_rows[1]  = '{32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, M_KEEP, M_KEEP, 1,
                              32'hFFFFFFFF};
        directed_rows[2]  = '{32'hFF102030, 32'h00FFFFFF, 0, 0, M_KEEP, M_KEEP, 1,
                              32'hFF102030};
        directed_rows[3]  = '{32'h00102030, 32'hFFA0B0C0, 0, 0, M_KEEP, M_KEEP, 1,
                              32'hFFA0B0C0};
        directed_rows[4]  = '{32'h80FFFFFF, 32'h80FFFFFF, 0, 0, M_KEEP, M_KEEP, 0, 0};
        directed_rows[5]  = '{32'h01FFFFFF, 32'h01FFFFFF, 0, 0, M_KEEP, M_KEEP, 0, 0};
        directed_rows[6]  = '{32'h7F123456, 32'h40ABCDEF, 1, 0, M_KEEP, M_KEEP, 0, 0};
        directed_rows[7]  = '{32'hFF123456, 32'hFFABCDEF, 1, 1, M_MASK, M_MASK, 1, 32'h0};
        directed_rows[8]  = '{32'h00123456, 32'h00ABCDEF, 0, 1, M_MASK, M_MASK, 1,
                              32'hFF123456};
        directed_rows[9]  = '{32'h00123456, 32'h00ABCDEF, 1, 0, M_MASK, M_MASK, 1,
                              32'hFFABCDEF};
        directed_rows[10] = '{32'h00123456, 32'h00ABCDEF, 1, 1, M_OPQ, M_OPQ, 1,
                              32'hFFABCDEF};
        directed_rows[11] = '{32'h00FFFFFF, 32'h00000000, 1, 1, M_OPQ, M_KEEP, 1,
                              32'hFFFFFFFF};
        directed_rows[12] = '{32'h55AA55AA, 32'hAA55AA55, 0, 0, M_UNDEF, M_UNDEF, 0, 0};
        directed_rows[13] = '{32'h00000000, 32'h00000000, 1, 1, M_UNDEF, M_UNDEF, 1, 32'h0};
        directed_rows[14] = '{32'hFFFFFFFF, 32'h7FFFFFFF, 0, 1, M_OPQ, M_MASK, 1,
                              32'hFFFFFFFF};
        directed_rows[15] = '{32'h30FF00FF, 32'h9000FF00, 0, 0, M_MASK, M_KEEP, 0, 0};
        directed_rows[16] = '{32'hC0FEFDFC, 32'h3F010203, 1, 0, M_KEEP, M_OPQ, 0, 0};
        directed_rows[17] = '{32'h00000000, 32'hFFFFFFFF, 0, 0, M_MASK, M_KEEP, 1,
                              32'hFFFFFFFF};
        directed_rows[18] = '{32'h01000000, 32'hFE000000, 0, 0, M_KEEP, M_UNDEF, 0, 0};
        directed_rows[19] = '{32'hFE808080, 32'h017F7F7F, 0, 0, M_KEEP, M_KEEP, 0, 0};

        bmodes = '{M_KEEP, M_MASK, M_OPQ, M_UNDEF, M_MASK, M_KEEP};
        tmodes = '{M_KEEP, M_OPQ, M_MASK, M_UNDEF, M_MASK, M_OPQ};

        rst_n = 1'b0;
        push = 1'b0;
        bottom_pixel = '0;
        top_pixel = '0;
        bottom_mask_bit = 1'b0;
        top_mask_bit = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = aoc_pkg::CFG_BOTTOM_MODE;
        cfg_data = M_KEEP;
        bottom_mode_q = M_KEEP;
        top_mode_q = M_KEEP;
        mismatch_count = 0;
        idle_cycles = 0;
        results_seen = 0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed table; modes rewritten only when a row changes them.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].bottom_mode != bottom_mode_q ||
                directed_rows[i].top_mode != top_mode_q) begin
                drop_push();
                wait_idle();
                write_mode(aoc_pkg::CFG_BOTTOM_MODE, directed_rows[i].bottom_mode);
                write_mode(aoc_pkg::CFG_TOP_MODE, directed_rows[i].top_mode);
            end
            send_pair(directed_rows[i].bottom, directed_rows[i].top,
                      directed_rows[i].bottom_mask, directed_rows[i].top_mask,
                      directed_rows[i].known, directed_rows[i].blended);
        end
        drop_push();
        wait_idle();

        // Long receiver hold-off while the sender keeps pushing: fills both queues.
        write_mode(aoc_pkg::CFG_BOTTOM_MODE, M_KEEP);
        write_mode(aoc_pkg::CFG_TOP_MODE, M_KEEP);
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int k = 0; k < 50; k++)
                    send_pair(random_pixel(), random_pixel(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'b0, 32'd0);
                drop_push();
            end
        join
        wait_idle();

        // Random phases across mode settings, extremes included.
        foreach (bmodes[p]) begin
            write_mode(aoc_pkg::CFG_BOTTOM_MODE, bmodes[p]);
            write_mode(aoc_pkg::CFG_TOP_MODE, tmodes[p]);
            random_phase(RANDOM_ITEMS / 6);
            wait_idle();
        end

        stim_done = 1'b1;
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/aoc_pkg.sv
hdl/aoc_fifo.sv
hdl/aoc_front.sv
hdl/aoc_back.sv
hdl/argb_over_compositor_core.sv
tb/tb_argb_over_compositor_core.sv
